// File: hw/rtl/sd_spi_host_sequencer_assert.svh
// ----------------------------------------------------------------------------
// SD SPI host sequencer assertion macros
// Shared property forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_HOST_SEQUENCER_ASSERT_SVH
`define SD_SPI_HOST_SEQUENCER_ASSERT_SVH

// same-cycle implication, clocked on clk, idle during reset
`define SHS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sd_spi_host_sequencer assertion failed");

// next-cycle implication
`define SHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sd_spi_host_sequencer assertion failed");

`endif

// File: hw/rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer package
// Types, codes and command tables shared by the sequencer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shs_pkg;

    localparam int SECTOR_BYTES       = 512;
    localparam int SPIN_BYTES_DEF     = 200;
    localparam int CSD_READ_BYTES_DEF = 18;
    localparam int CSD_STORE          = 18;
    localparam int CSD_IDX_W          = 5;
    localparam int COUNT_W            = 11;
    localparam int V1_TRIES           = 19;
    localparam int V2_INNER_TRIES     = 19999;
    localparam int V2_OUTER_TRIES     = 48;

    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_XFER = 2'd3;

    localparam logic [1:0] REG_RESP_LIMIT  = 2'd0;
    localparam logic [1:0] REG_TOKEN_LIMIT = 2'd1;
    localparam logic [1:0] REG_BUSY_LIMIT  = 2'd2;
    localparam logic [1:0] REG_ATTEMPTS    = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_RESET_FAIL  = 2'd1;
    localparam logic [1:0] ST_REJECTED    = 2'd2;
    localparam logic [1:0] ST_TOKEN_TIMEO = 2'd3;

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] START_TOKEN = 8'hFE;

    typedef enum logic [3:0] {
        PH_IDLE, PH_FILL, PH_CMD, PH_RESP, PH_PUMP, PH_OCR, PH_TOKEN,
        PH_RDATA, PH_WGAP, PH_WTOK, PH_WDATA, PH_BUSY
    } phase_t;

    typedef enum logic [3:0] {
        K_GO, K_COND, K_APP, K_ACMD41, K_OCR, K_OP1, K_BLEN, K_CSD, K_RD, K_WR
    } kind_t;

    typedef enum logic [4:0] {
        N_CMD0, N_CMD8, N_V1_FIRST, N_V1_NEXT, N_V1_OK, N_V2_BEGIN, N_INNER_FIRST,
        N_CMD41, N_INNER_NEXT, N_CMD58, N_OCR_DONE, N_CMD9, N_CSD_DONE, N_FIN_OK,
        N_RD_SEL, N_CMD17, N_RD_DONE, N_WR_SEL, N_CMD24, N_WR_BUSY, N_WR_END
    } next_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] sector_address;
        logic [7:0]  rx_byte;
        logic [7:0]  write_byte;
    } req_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        chip_select;
        logic        fast_clock;
        logic [7:0]  data_out;
        logic        data_out_valid;
        logic        need_write_byte;
        logic        done_res;
        logic [1:0]  status;
        logic        card_is_sdhc;
        logic [31:0] card_blocks;
    } res_t;

    typedef struct packed {
        phase_t               phase;
        logic [COUNT_W-1:0]   byte_count;
        logic [20:0]          poll_count;
        logic [15:0]          retry_count;
        logic [5:0]           outer_tries;
        logic [COUNT_W-1:0]   fill_len;
        next_t                fill_next;
        kind_t                cmd_kind;
        logic                 cs_on;
        logic                 fast_on;
        logic                 csd_xfer;
        logic [7:0]           wr_hold;
        logic                 block_addressing;
        logic [31:0]          capacity_blocks;
        logic [31:0]          response_word;
        logic [31:0]          address_latch;
        logic                 done;
        logic [1:0]           status;
    } ctx_t;

    typedef struct packed {
        logic [15:0] resp_limit;
        logic [20:0] token_limit;
        logic [16:0] busy_limit;
        logic [3:0]  attempts;
        logic [31:0] csd_cap;
    } env_t;

    function automatic logic [7:0] kind_index(kind_t k);
        logic [7:0] v;
        unique case (k)
            K_GO:     v = 8'h40;
            K_COND:   v = 8'h48;
            K_APP:    v = 8'h77;
            K_ACMD41: v = 8'h69;
            K_OCR:    v = 8'h7A;
            K_OP1:    v = 8'h41;
            K_BLEN:   v = 8'h50;
            K_CSD:    v = 8'h49;
            K_RD:     v = 8'h51;
            K_WR:     v = 8'h58;
            default:  v = 8'h40;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] kind_crc(kind_t k);
        logic [7:0] v;
        unique case (k)
            K_GO:              v = 8'h95;
            K_COND, K_ACMD41:  v = 8'h87;
            default:           v = 8'hFF;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] kind_arg(kind_t k);
        logic [31:0] v;
        unique case (k)
            K_COND:   v = 32'h0000_01AA;
            K_ACMD41: v = 32'h4000_0000;
            K_BLEN:   v = 32'h0000_0001;
            default:  v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/sd_spi_host_sequencer.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer
// Byte-level SPI-mode SD card init, sector read and sector write control.
// ----------------------------------------------------------------------------
// For each request, the sequencer state and the next byte to send
// are worked out in one pass from the state registers and the request, and the
// result lands in an output register. A request is taken every cycle while that
// register is empty or being drained. A card exchange is one request with
// operation 3; init, read and write requests start (or restart) an operation.
// The CSD store is filled only by a card read during init.
`timescale 1ns / 1ps

module sd_spi_host_sequencer
    import shs_pkg::*;
#(
    parameter int SPIN_BYTES     = SPIN_BYTES_DEF,
    parameter int CSD_READ_BYTES = CSD_READ_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [COUNT_W-1:0] SpinCount   = COUNT_W'(SPIN_BYTES);
    localparam logic [COUNT_W-1:0] CsdCount    = COUNT_W'(CSD_READ_BYTES);
    localparam logic [COUNT_W-1:0] SectorCount = COUNT_W'(SECTOR_BYTES);
    localparam logic [COUNT_W-1:0] CsdStore    = COUNT_W'(CSD_STORE);

    logic [15:0] resp_limit_reg;
    logic [20:0] token_limit_reg;
    logic [16:0] busy_limit_reg;
    logic [3:0]  attempts_reg;
    ctx_t        ctx_reg, ctx_next;
    res_t        res_reg, res_next;
    logic        res_valid_reg;
    logic [7:0]  csd_mem [CSD_STORE];
    env_t        env;
    logic        accept;
    logic        csd_wr;
    logic [7:0]  dv_data;
    logic        dv;

    function automatic ctx_t f_finish(ctx_t c, logic [1:0] st);
        c.phase = PH_IDLE;
        c.cs_on = 1'b0;
        c.fast_on = 1'b0;
        c.done = 1'b1;
        c.status = st;
        return c;
    endfunction

    function automatic ctx_t f_fill(ctx_t c, logic [COUNT_W-1:0] n, next_t nx);
        c.phase = PH_FILL;
        c.byte_count = '0;
        c.fill_len = n;
        c.fill_next = nx;
        return c;
    endfunction

    function automatic ctx_t f_cmd(ctx_t c, kind_t k);
        c.phase = PH_CMD;
        c.cmd_kind = k;
        c.byte_count = '0;
        return c;
    endfunction

    function automatic ctx_t f_after_sdhc(ctx_t c, logic s);
        c.block_addressing = s;
        if (!s)
        begin
            c = f_cmd(c, K_BLEN);
        end
        else
        begin
            c = f_fill(c, COUNT_W'(1), N_CMD9);
        end
        return c;
    endfunction

    function automatic ctx_t f_outer_end(ctx_t c);
        c.outer_tries = c.outer_tries + 6'd1;
        if (c.outer_tries >= 6'(V2_OUTER_TRIES))
        begin
            c = f_after_sdhc(c, 1'b0);
        end
        else
        begin
            c = f_fill(c, SpinCount, N_INNER_FIRST);
        end
        return c;
    endfunction

    function automatic ctx_t f_inner_next(ctx_t c);
        c.retry_count = c.retry_count + 16'd1;
        if (c.retry_count >= 16'(V2_INNER_TRIES))
        begin
            c = f_outer_end(c);
        end
        else
        begin
            c = f_cmd(c, K_APP);
        end
        return c;
    endfunction

    function automatic ctx_t f_csd_done(ctx_t c, env_t e);
        c.capacity_blocks = e.csd_cap;
        c.cs_on = 1'b0;
        return f_fill(c, COUNT_W'(1), N_FIN_OK);
    endfunction

    function automatic ctx_t f_token_timeout(ctx_t c, env_t e);
        if (c.csd_xfer)
        begin
            c = f_csd_done(c, e);
        end
        else
        begin
            c = f_finish(c, ST_TOKEN_TIMEO);
        end
        return c;
    endfunction

    function automatic ctx_t f_enter_token(ctx_t c, logic csd, env_t e);
        c.csd_xfer = csd;
        c.poll_count = '0;
        if (e.token_limit <= 21'd1)
        begin
            c = f_token_timeout(c, e);
        end
        else
        begin
            c.phase = PH_TOKEN;
        end
        return c;
    endfunction

    function automatic ctx_t f_resume(ctx_t c, env_t e);
        unique case (c.fill_next)
            N_CMD0:
            begin
                c.cs_on = 1'b1;
                c = f_cmd(c, K_GO);
            end
            N_CMD8:        c = f_cmd(c, K_COND);
            N_V1_FIRST:
            begin
                c.retry_count = '0;
                c = f_cmd(c, K_OP1);
            end
            N_V1_NEXT:
            begin
                if (c.retry_count >= 16'(V1_TRIES))
                begin
                    c = f_after_sdhc(c, 1'b0);
                end
                else
                begin
                    c = f_cmd(c, K_OP1);
                end
            end
            N_V1_OK:       c = f_after_sdhc(c, 1'b0);
            N_V2_BEGIN:
            begin
                c.outer_tries = '0;
                c = f_fill(c, SpinCount, N_INNER_FIRST);
            end
            N_INNER_FIRST:
            begin
                c.retry_count = '0;
                c = f_cmd(c, K_APP);
            end
            N_CMD41:       c = f_cmd(c, K_ACMD41);
            N_INNER_NEXT:  c = f_inner_next(c);
            N_CMD58:       c = f_cmd(c, K_OCR);
            N_OCR_DONE:    c = f_after_sdhc(c, c.response_word[6]);
            N_CMD9:        c = f_cmd(c, K_CSD);
            N_CSD_DONE:    c = f_csd_done(c, e);
            N_RD_SEL, N_WR_SEL:
            begin
                c.cs_on = 1'b1;
                c.fast_on = 1'b1;
                c = f_fill(c, COUNT_W'(1), (c.fill_next == N_RD_SEL) ? N_CMD17 : N_CMD24);
            end
            N_CMD17:       c = f_cmd(c, K_RD);
            N_CMD24:       c = f_cmd(c, K_WR);
            N_WR_BUSY:
            begin
                c.poll_count = '0;
                c.phase = PH_BUSY;
            end
            default:       c = f_finish(c, ST_OK);
        endcase
        return c;
    endfunction

    function automatic ctx_t f_cmd_done(ctx_t c, logic [7:0] rx, env_t e);
        unique case (c.cmd_kind)
            K_GO:
            begin
                if (rx == 8'h01)
                begin
                    c = f_fill(c, SpinCount, N_CMD8);
                end
                else
                begin
                    c.retry_count = c.retry_count + 16'd1;
                    if (c.retry_count >= 16'(e.attempts))
                    begin
                        c = f_finish(c, ST_RESET_FAIL);
                    end
                    else
                    begin
                        c.cs_on = 1'b0;
                        c = f_fill(c, SpinCount, N_CMD0);
                    end
                end
            end
            K_COND:
            begin
                if (rx != 8'h01)
                begin
                    c = f_fill(c, COUNT_W'(1), N_V1_FIRST);
                end
                else
                begin
                    c.phase = PH_PUMP;
                    c.byte_count = '0;
                    c.response_word = '0;
                end
            end
            K_APP:
            begin
                if (rx == 8'h01) c = f_fill(c, COUNT_W'(1), N_CMD41);
                else c = f_inner_next(c);
            end
            K_ACMD41:
            begin
                if (rx == 8'h00) c = f_fill(c, COUNT_W'(1), N_CMD58);
                else c = f_fill(c, SpinCount, N_INNER_NEXT);
            end
            K_OCR:
            begin
                if (rx == 8'h00) c.phase = PH_OCR;
                else c = f_outer_end(c);
            end
            K_OP1:
            begin
                if (rx == 8'h00)
                begin
                    c = f_fill(c, COUNT_W'(1), N_V1_OK);
                end
                else
                begin
                    c.retry_count = c.retry_count + 16'd1;
                    c = f_fill(c, SpinCount, N_V1_NEXT);
                end
            end
            K_BLEN:  c = f_fill(c, COUNT_W'(1), N_CMD9);
            K_CSD:   c = f_enter_token(c, 1'b1, e);
            K_RD:
            begin
                if (rx != 8'h00) c = f_finish(c, ST_REJECTED);
                else c = f_enter_token(c, 1'b0, e);
            end
            default:
            begin
                if (rx != 8'h00) c = f_finish(c, ST_REJECTED);
                else c.phase = PH_WGAP;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_cmd_tx(ctx_t c);
        logic [31:0] arg;
        logic [7:0]  v;
        arg = (c.cmd_kind == K_RD || c.cmd_kind == K_WR) ? c.address_latch
                                                         : kind_arg(c.cmd_kind);
        if (!c.block_addressing)
        begin
            arg = {arg[22:0], 9'd0};
        end
        priority if (c.byte_count == '0)
        begin
            v = kind_index(c.cmd_kind);
        end
        else if (c.byte_count >= COUNT_W'(5))
        begin
            v = kind_crc(c.cmd_kind);
        end
        else
        begin
            unique case (c.byte_count[1:0])
                2'd1:    v = arg[31:24];
                2'd2:    v = arg[23:16];
                2'd3:    v = arg[15:8];
                default: v = arg[7:0];
            endcase
        end
        return v;
    endfunction

    // CSD capacity decode and limit environment
    always_comb
    begin
        logic [21:0] c_size2;
        logic [11:0] c_size1;
        logic [2:0]  mul;
        logic [3:0]  bl;
        logic [31:0] blk;
        c_size2 = {csd_mem[7][5:0], csd_mem[8], csd_mem[9]};
        c_size1 = {csd_mem[6][1:0], csd_mem[7], csd_mem[8][7:6]};
        mul = {csd_mem[9][1:0], csd_mem[10][7]};
        bl = csd_mem[5][3:0];
        blk = (32'(c_size1) + 32'd1) << (32'd2 + 32'(mul));
        if (bl > 4'd9)
        begin
            blk = blk << (bl - 4'd9);
        end
        env.resp_limit = resp_limit_reg;
        env.token_limit = token_limit_reg;
        env.busy_limit = busy_limit_reg;
        env.attempts = attempts_reg;
        if (csd_mem[0][7:6] == 2'b01)
        begin
            env.csd_cap = (c_size2 == 22'h3F_FFFF) ? 32'hFFFF_FFFF
                                                   : (32'(c_size2) + 32'd1) << 10;
        end
        else
        begin
            env.csd_cap = blk;
        end
    end

    assign accept = req_valid && req_ready;
    assign req_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign pready = 1'b1;

    // next state
    always_comb
    begin
        logic [15:0] rlim;
        logic [16:0] blim;
        ctx_t        c;
        c = ctx_reg;
        c.done = 1'b0;
        c.status = ST_OK;
        dv = 1'b0;
        dv_data = 8'h00;
        csd_wr = 1'b0;
        rlim = (env.resp_limit != '0) ? env.resp_limit : 16'd1;
        blim = (env.busy_limit != '0) ? env.busy_limit : 17'd1;
        priority if (req.operation == OP_INIT)
        begin
            c.block_addressing = 1'b1;
            c.cs_on = 1'b0;
            c.fast_on = 1'b0;
            c.retry_count = '0;
            c = f_fill(c, SpinCount, N_CMD0);
        end
        else if (req.operation == OP_READ || req.operation == OP_WRITE)
        begin
            c.address_latch = req.sector_address;
            c.cs_on = 1'b0;
            c.fast_on = 1'b0;
            c = f_fill(c, COUNT_W'(1), (req.operation == OP_READ) ? N_RD_SEL : N_WR_SEL);
        end
        else
        begin
            unique case (c.phase)
                PH_FILL:
                begin
                    c.byte_count = c.byte_count + 1'b1;
                    if (c.byte_count >= c.fill_len) c = f_resume(c, env);
                end
                PH_CMD:
                begin
                    if (c.byte_count < COUNT_W'(5))
                    begin
                        c.byte_count = c.byte_count + 1'b1;
                    end
                    else
                    begin
                        c.poll_count = 21'd1;
                        if (req.rx_byte != IDLE_BYTE || rlim == 16'd1)
                            c = f_cmd_done(c, req.rx_byte, env);
                        else
                            c.phase = PH_RESP;
                    end
                end
                PH_RESP:
                begin
                    c.poll_count = c.poll_count + 21'd1;
                    if (req.rx_byte != IDLE_BYTE || c.poll_count >= 21'(rlim))
                        c = f_cmd_done(c, req.rx_byte, env);
                end
                PH_PUMP:
                begin
                    c.response_word = {c.response_word[23:0], req.rx_byte};
                    c.byte_count = c.byte_count + 1'b1;
                    if (c.byte_count >= COUNT_W'(4))
                        c = f_fill(c, COUNT_W'(1), (c.response_word[15:0] != 16'h01AA)
                                   ? N_V1_FIRST : N_V2_BEGIN);
                end
                PH_OCR:
                begin
                    c.response_word = 32'(req.rx_byte);
                    c = f_fill(c, COUNT_W'(4), N_OCR_DONE);
                end
                PH_TOKEN:
                begin
                    c.poll_count = c.poll_count + 21'd1;
                    if (req.rx_byte == START_TOKEN)
                    begin
                        c.phase = PH_RDATA;
                        c.byte_count = '0;
                    end
                    else if (c.poll_count >= env.token_limit - 21'd1)
                    begin
                        c = f_token_timeout(c, env);
                    end
                end
                PH_RDATA:
                begin
                    if (c.csd_xfer)
                    begin
                        csd_wr = (c.byte_count < CsdStore);
                    end
                    else
                    begin
                        dv = 1'b1;
                        dv_data = req.rx_byte;
                    end
                    c.byte_count = c.byte_count + 1'b1;
                    if (c.byte_count >= (c.csd_xfer ? CsdCount : SectorCount))
                        c = f_fill(c, COUNT_W'(2), c.csd_xfer ? N_CSD_DONE : N_RD_DONE);
                end
                PH_WGAP:  c.phase = PH_WTOK;
                PH_WTOK:
                begin
                    c.phase = PH_WDATA;
                    c.byte_count = '0;
                    c.wr_hold = req.write_byte;
                end
                PH_WDATA:
                begin
                    c.byte_count = c.byte_count + 1'b1;
                    if (c.byte_count >= SectorCount)
                        c = f_fill(c, COUNT_W'(3), N_WR_BUSY);
                    else
                        c.wr_hold = req.write_byte;
                end
                PH_BUSY:
                begin
                    c.poll_count = c.poll_count + 21'd1;
                    if (req.rx_byte != 8'h00 || c.poll_count >= 21'(blim))
                        c = f_fill(c, COUNT_W'(1), N_WR_END);
                end
                default:  c.phase = PH_IDLE;
            endcase
        end
        ctx_next = c;
    end

    // result
    always_comb
    begin
        unique case (ctx_next.phase)
            PH_CMD:   res_next.tx_byte = f_cmd_tx(ctx_next);
            PH_WTOK:  res_next.tx_byte = START_TOKEN;
            PH_WDATA: res_next.tx_byte = ctx_next.wr_hold;
            default:  res_next.tx_byte = IDLE_BYTE;
        endcase
        res_next.chip_select = ctx_next.cs_on;
        res_next.fast_clock = ctx_next.fast_on;
        res_next.data_out = dv_data;
        res_next.data_out_valid = dv;
        res_next.need_write_byte = (ctx_next.phase == PH_WTOK)
            || (ctx_next.phase == PH_WDATA && ctx_next.byte_count < SectorCount - 1'b1);
        res_next.done_res = ctx_next.done;
        res_next.status = ctx_next.status;
        res_next.card_is_sdhc = ctx_next.block_addressing;
        res_next.card_blocks = ctx_next.capacity_blocks;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '{phase: PH_IDLE, fill_next: N_CMD0, cmd_kind: K_GO,
                         block_addressing: 1'b1, default: '0};
            res_valid_reg <= 1'b0;
            resp_limit_reg <= 16'd40000;
            token_limit_reg <= 21'd1500000;
            busy_limit_reg <= 17'd100000;
            attempts_reg <= 4'd6;
        end
        else
        begin
            if (accept)
            begin
                ctx_reg <= ctx_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    REG_RESP_LIMIT:  resp_limit_reg <= pwdata[15:0];
                    REG_TOKEN_LIMIT: token_limit_reg <= pwdata[20:0];
                    REG_BUSY_LIMIT:  busy_limit_reg <= pwdata[16:0];
                    default:         attempts_reg <= pwdata[3:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
            if (req.operation == OP_XFER && ctx_reg.phase != PH_IDLE && csd_wr)
            begin
                csd_mem[ctx_reg.byte_count[CSD_IDX_W-1:0]] <= req.rx_byte;
            end
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RESP_LIMIT:  prdata = 32'(resp_limit_reg);
            REG_TOKEN_LIMIT: prdata = 32'(token_limit_reg);
            REG_BUSY_LIMIT:  prdata = 32'(busy_limit_reg);
            default:         prdata = 32'(attempts_reg);
        endcase
    end

endmodule

// File: hw/rtl/shs_checker.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer checker
// Port-level properties of the sequencer result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sd_spi_host_sequencer_assert.svh"

module shs_checker
    import shs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    `SHS_ASSERT_IMPL(a_status_needs_done, res_valid && res.status != ST_OK, res.done_res)
    `SHS_ASSERT_IMPL(a_done_releases, res_valid && res.done_res,
                     !res.chip_select && !res.fast_clock)
    `SHS_ASSERT_IMPL(a_write_selected, res_valid && res.need_write_byte,
                     res.chip_select && res.fast_clock)
    `SHS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

endmodule

bind sd_spi_host_sequencer shs_checker u_shs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// File: tb/sv/sd_spi_host_sequencer_tb.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer testbench
// Drives init, sector read and sector write requests plus card byte exchanges,
// with card replies shaped from a predicted sequencer state. Every result is
// checked against a bench predictor or a listed value, across several limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sd_spi_host_sequencer_tb;
    import shs_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 300;
    localparam int PHASES = 6;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [7:0]  rx;
        logic [7:0]  wb;
        bit          typed;
        res_t        want;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    res_t        pending_replies[$];
    step_row_t   steps[$];
    int          errors;
    int          items;
    int          idle_cycles;
    bit          calm;

    // predicted sequencer state
    phase_t      ph;
    int unsigned bc, pc, rc, ot, flen;
    next_t       fnext;
    kind_t       ck;
    bit          cs_on, fast_on, csd_x, blk_addr;
    logic [7:0]  whold;
    logic [31:0] cap, rword, alatch;
    logic [7:0]  csd[CSD_STORE];
    logic [CSD_STORE-1:0] csd_seen;
    logic [15:0] lim_resp;
    logic [20:0] lim_tok;
    logic [16:0] lim_busy;
    logic [3:0]  lim_att;
    bit          o_done, o_dv;
    logic [1:0]  o_st;
    logic [7:0]  o_data;

    sd_spi_host_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    function automatic logic [7:0] cmd_index_byte(kind_t k);
        case (k)
            K_GO:     return 8'h40;
            K_COND:   return 8'h48;
            K_APP:    return 8'h77;
            K_ACMD41: return 8'h69;
            K_OCR:    return 8'h7A;
            K_OP1:    return 8'h41;
            K_BLEN:   return 8'h50;
            K_CSD:    return 8'h49;
            K_RD:     return 8'h51;
            default:  return 8'h58;
        endcase
    endfunction

    function automatic logic [7:0] cmd_crc_byte(kind_t k);
        case (k)
            K_GO:             return 8'h95;
            K_COND, K_ACMD41: return 8'h87;
            default:          return 8'hFF;
        endcase
    endfunction

    function automatic logic [31:0] cmd_arg_word(kind_t k);
        case (k)
            K_COND:   return 32'h0000_01AA;
            K_ACMD41: return 32'h4000_0000;
            K_BLEN:   return 32'h0000_0001;
            default:  return 32'h0;
        endcase
    endfunction

    function void seq_reset();
        lim_resp = 16'd40000; lim_tok = 21'd1500000; lim_busy = 17'd100000; lim_att = 4'd6;
        ph = PH_IDLE; bc = 0; pc = 0; rc = 0; ot = 0; flen = 0; fnext = N_CMD0; ck = K_GO;
        cs_on = 0; fast_on = 0; csd_x = 0; blk_addr = 1; whold = 0;
        cap = 0; rword = 0; alatch = 0; csd_seen = '0;
        for (int i = 0; i < CSD_STORE; i++) csd[i] = 0;
    endfunction

    function void end_op(logic [1:0] st);
        ph = PH_IDLE; cs_on = 0; fast_on = 0; o_done = 1; o_st = st;
    endfunction

    function void fill(int unsigned n, next_t nx);
        ph = PH_FILL; bc = 0; flen = n; fnext = nx;
    endfunction

    function void issue(kind_t k);
        ph = PH_CMD; ck = k; bc = 0;
    endfunction

    function logic [7:0] cmd_byte();
        logic [31:0] a;
        logic [31:0] sh;
        if (bc == 0) return cmd_index_byte(ck);
        if (bc >= 5) return cmd_crc_byte(ck);
        a = (ck == K_RD || ck == K_WR) ? alatch : cmd_arg_word(ck);
        if (!blk_addr) a = a << 9;
        sh = a >> (8 * (4 - bc));
        return sh[7:0];
    endfunction

    function void csd_capacity();
        logic [21:0] c;
        logic [63:0] big;
        logic [2:0]  mul;
        logic [3:0]  bl;
        logic [11:0] csz;
        logic [31:0] blk;
        if (csd[0][7:6] == 2'b01) begin
            c = {csd[7][5:0], csd[8], csd[9]};
            big = (64'(c) + 64'd1) << 10;
            cap = (big > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : big[31:0];
        end else begin
            mul = {csd[9][1:0], csd[10][7]};
            bl = csd[5][3:0];
            csz = {csd[6][1:0], csd[7], csd[8][7:6]};
            blk = (32'(csz) + 32'd1) << (2 + mul);
            if (bl > 9) blk = blk << (bl - 9);
            cap = blk;
        end
    endfunction

    function void card_type(bit s);
        blk_addr = s;
        if (!s) issue(K_BLEN);
        else fill(1, N_CMD9);
    endfunction

    function void outer_try();
        ot++;
        if (ot >= V2_OUTER_TRIES) card_type(0);
        else fill(SPIN_BYTES_DEF, N_INNER_FIRST);
    endfunction

    function void inner_try();
        rc++;
        if (rc >= V2_INNER_TRIES) outer_try();
        else issue(K_APP);
    endfunction

    function void csd_finish();
        csd_capacity();
        cs_on = 0;
        fill(1, N_FIN_OK);
    endfunction

    function void token_expired();
        if (csd_x) csd_finish();
        else end_op(ST_TOKEN_TIMEO);
    endfunction

    function void token_wait(bit csd_read);
        csd_x = csd_read; pc = 0;
        if (lim_tok <= 1) token_expired();
        else ph = PH_TOKEN;
    endfunction

    function void fill_done(next_t nx);
        case (nx)
            N_CMD0:        begin cs_on = 1; issue(K_GO); end
            N_CMD8:        issue(K_COND);
            N_V1_FIRST:    begin rc = 0; issue(K_OP1); end
            N_V1_NEXT:     if (rc >= V1_TRIES) card_type(0); else issue(K_OP1);
            N_V1_OK:       card_type(0);
            N_V2_BEGIN:    begin ot = 0; fill(SPIN_BYTES_DEF, N_INNER_FIRST); end
            N_INNER_FIRST: begin rc = 0; issue(K_APP); end
            N_CMD41:       issue(K_ACMD41);
            N_INNER_NEXT:  inner_try();
            N_CMD58:       issue(K_OCR);
            N_OCR_DONE:    card_type(rword[6]);
            N_CMD9:        issue(K_CSD);
            N_CSD_DONE:    csd_finish();
            N_RD_SEL:      begin cs_on = 1; fast_on = 1; fill(1, N_CMD17); end
            N_CMD17:       issue(K_RD);
            N_WR_SEL:      begin cs_on = 1; fast_on = 1; fill(1, N_CMD24); end
            N_CMD24:       issue(K_WR);
            N_WR_BUSY:     begin pc = 0; ph = PH_BUSY; end
            default:       end_op(ST_OK);
        endcase
    endfunction

    function void response_in(logic [7:0] rx);
        case (ck)
            K_GO: begin
                if (rx == 8'h01) fill(SPIN_BYTES_DEF, N_CMD8);
                else begin
                    rc++;
                    if (rc >= lim_att) end_op(ST_RESET_FAIL);
                    else begin
                        cs_on = 0;
                        fill(SPIN_BYTES_DEF, N_CMD0);
                    end
                end
            end
            K_COND:
                if (rx != 8'h01) fill(1, N_V1_FIRST);
                else begin
                    ph = PH_PUMP; bc = 0; rword = 0;
                end
            K_APP:    if (rx == 8'h01) fill(1, N_CMD41); else inner_try();
            K_ACMD41: if (rx == 8'h00) fill(1, N_CMD58); else fill(SPIN_BYTES_DEF, N_INNER_NEXT);
            K_OCR:    if (rx == 8'h00) ph = PH_OCR; else outer_try();
            K_OP1:
                if (rx == 8'h00) fill(1, N_V1_OK);
                else begin
                    rc++;
                    fill(SPIN_BYTES_DEF, N_V1_NEXT);
                end
            K_BLEN:   fill(1, N_CMD9);
            K_CSD:    token_wait(1);
            K_RD:     if (rx != 8'h00) end_op(ST_REJECTED); else token_wait(0);
            default:  if (rx != 8'h00) end_op(ST_REJECTED); else ph = PH_WGAP;
        endcase
    endfunction

    function void exchange_in(logic [7:0] rx, logic [7:0] wb);
        int unsigned lim;
        lim = (lim_resp == 0) ? 1 : lim_resp;
        case (ph)
            PH_FILL: begin
                bc++;
                if (bc >= flen) fill_done(fnext);
            end
            PH_CMD:
                if (bc < 5) bc++;
                else begin
                    pc = 1;
                    if (rx != 8'hFF || pc >= lim) response_in(rx);
                    else ph = PH_RESP;
                end
            PH_RESP: begin
                pc++;
                if (rx != 8'hFF || pc >= lim) response_in(rx);
            end
            PH_PUMP: begin
                rword = {rword[23:0], rx};
                bc++;
                if (bc >= 4) fill(1, (rword[15:0] != 16'h01AA) ? N_V1_FIRST : N_V2_BEGIN);
            end
            PH_OCR: begin
                rword = {24'h0, rx};
                fill(4, N_OCR_DONE);
            end
            PH_TOKEN: begin
                pc++;
                if (rx == START_TOKEN) begin
                    ph = PH_RDATA; bc = 0;
                end else if (pc >= int'(lim_tok) - 1) token_expired();
            end
            PH_RDATA: begin
                if (csd_x) begin
                    if (bc < CSD_STORE) begin
                        csd[bc] = rx;
                        csd_seen[bc] = 1'b1;
                    end
                end else begin
                    o_data = rx; o_dv = 1;
                end
                bc++;
                if (bc >= (csd_x ? CSD_READ_BYTES_DEF : SECTOR_BYTES))
                    fill(2, csd_x ? N_CSD_DONE : N_RD_DONE);
            end
            PH_WGAP: ph = PH_WTOK;
            PH_WTOK: begin
                ph = PH_WDATA; bc = 0; whold = wb;
            end
            PH_WDATA: begin
                bc++;
                if (bc >= SECTOR_BYTES) fill(3, N_WR_BUSY);
                else whold = wb;
            end
            PH_BUSY: begin
                pc++;
                if (rx != 8'h00 || pc >= ((lim_busy == 0) ? 1 : lim_busy)) fill(1, N_WR_END);
            end
            default: ph = PH_IDLE;
        endcase
    endfunction

    function res_t sequence_exchange(req_t r);
        res_t e;
        o_done = 0; o_st = ST_OK; o_dv = 0; o_data = 0;
        if (r.operation == OP_INIT) begin
            blk_addr = 1; cs_on = 0; fast_on = 0; rc = 0;
            fill(SPIN_BYTES_DEF, N_CMD0);
        end else if (r.operation == OP_READ || r.operation == OP_WRITE) begin
            alatch = r.sector_address;
            cs_on = 0; fast_on = 0;
            fill(1, (r.operation == OP_READ) ? N_RD_SEL : N_WR_SEL);
        end else if (ph != PH_IDLE) begin
            exchange_in(r.rx_byte, r.write_byte);
        end
        if (ph == PH_CMD) e.tx_byte = cmd_byte();
        else if (ph == PH_WTOK) e.tx_byte = START_TOKEN;
        else if (ph == PH_WDATA) e.tx_byte = whold;
        else e.tx_byte = IDLE_BYTE;
        e.chip_select = cs_on;
        e.fast_clock = fast_on;
        e.data_out = o_data;
        e.data_out_valid = o_dv;
        e.need_write_byte = (ph == PH_WTOK) || (ph == PH_WDATA && bc < SECTOR_BYTES - 1);
        e.done_res = o_done;
        e.status = o_st;
        e.card_is_sdhc = blk_addr;
        e.card_blocks = cap;
        return e;
    endfunction

    function logic [7:0] card_reply();
        int n;
        if ((ph == PH_CMD && bc >= 5) || ph == PH_RESP) begin
            n = $urandom_range(0, 99);
            if (n < 25) return 8'hFF;
            if (n >= 88) return 8'($urandom);
            case (ck)
                K_GO, K_COND, K_APP: return 8'h01;
                K_ACMD41: return ($urandom_range(0, 4) == 0) ? 8'h01 : 8'h00;
                default: return 8'h00;
            endcase
        end
        if (ph == PH_PUMP && $urandom_range(0, 9) != 0)
            return (bc == 2) ? 8'h01 : ((bc == 3) ? 8'hAA : 8'h00);
        if (ph == PH_TOKEN) begin
            if (csd_x && csd_seen != '1 && pc + 2 >= lim_tok) return START_TOKEN;
            if ($urandom_range(0, 3) == 0) return START_TOKEN;
        end
        if (ph == PH_BUSY && $urandom_range(0, 3) != 0) return 8'h00;
        return 8'($urandom);
    endfunction

    function res_t typed_res(logic [7:0] tx, bit cs, bit fast, bit nw, bit dn, logic [1:0] st);
        res_t e;
        e = '0;
        e.tx_byte = tx; e.chip_select = cs; e.fast_clock = fast;
        e.need_write_byte = nw; e.done_res = dn; e.status = st; e.card_is_sdhc = 1'b1;
        return e;
    endfunction

    task send_item(input logic [1:0] op, input logic [31:0] addr, input logic [7:0] rx,
                   input logic [7:0] wb, input bit typed, input res_t want);
        int gap;
        req_t r;
        res_t e;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.operation = op; r.sector_address = addr; r.rx_byte = rx; r.write_byte = wb;
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        if (!(op == OP_XFER && ph == PH_IDLE)) items++;
        e = sequence_exchange(r);
        pending_replies.push_back(typed ? want : e);
    endtask

    task send_random(input logic [1:0] op, input logic [7:0] rx);
        send_item(op, $urandom, rx, 8'($urandom), 1'b0, '0);
    endtask

    task drain();
        req_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RESP_LIMIT:  lim_resp = value[15:0];
            REG_TOKEN_LIMIT: lim_tok = value[20:0];
            REG_BUSY_LIMIT:  lim_busy = value[16:0];
            default:         lim_att = value[3:0];
        endcase
        @(posedge clk);
    endtask

    task set_limits(input int resp, input int tok, input int busy, input int att);
        int t;
        t = tok;
        if (t <= 1 && csd_seen != '1) t = 2;
        reg_write(REG_RESP_LIMIT, resp);
        reg_write(REG_TOKEN_LIMIT, t);
        reg_write(REG_BUSY_LIMIT, busy);
        reg_write(REG_ATTEMPTS, att);
    endtask

    task run_operation();
        int pick;
        logic [1:0] op;
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) send_random(OP_XFER, 8'($urandom));
        pick = $urandom_range(0, 4);
        op = (pick == 0) ? OP_INIT : ((pick < 3) ? OP_READ : OP_WRITE);
        send_random(op, 8'($urandom));
        while (ph != PH_IDLE) begin
            if ($urandom_range(0, 299) == 0)
                send_random(2'($urandom_range(0, 2)), 8'($urandom));
            else
                send_random(OP_XFER, card_reply());
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        int limit;
        step_row_t s;
        rst_n = 1'b0; req_valid = 1'b0; req = '0; res_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; items = 0; calm = 0;
        seq_reset();
        steps.push_back('{OP_XFER, 32'h0, 8'hFF, 8'h00, 1, typed_res(8'hFF, 0, 0, 0, 0, ST_OK)});
        steps.push_back('{OP_READ, 32'hFFFF_FFFF, 8'h00, 8'hFF, 1,
                          typed_res(8'hFF, 0, 0, 0, 0, ST_OK)});
        steps.push_back('{OP_XFER, 32'h0, 8'h00, 8'h00, 1, typed_res(8'hFF, 1, 1, 0, 0, ST_OK)});
        steps.push_back('{OP_XFER, 32'h0, 8'hFF, 8'h00, 1, typed_res(8'h51, 1, 1, 0, 0, ST_OK)});
        for (int i = 0; i < 5; i++)
            steps.push_back('{OP_XFER, 32'h0, 8'hFF, 8'hFF, 0, '0});
        steps.push_back('{OP_XFER, 32'h0, 8'h05, 8'h00, 1,
                          typed_res(8'hFF, 0, 0, 0, 1, ST_REJECTED)});
        steps.push_back('{OP_WRITE, 32'h0, 8'hFF, 8'h00, 1, typed_res(8'hFF, 0, 0, 0, 0, ST_OK)});
        for (int i = 0; i < 7; i++)
            steps.push_back('{OP_XFER, 32'h0, 8'hFF, 8'h00, 0, '0});
        steps.push_back('{OP_XFER, 32'h0, 8'h00, 8'hFF, 0, '0});
        steps.push_back('{OP_XFER, 32'h0, 8'h00, 8'h00, 1, typed_res(8'hFE, 1, 1, 1, 0, ST_OK)});
        steps.push_back('{OP_XFER, 32'h0, 8'hFF, 8'hFF, 0, '0});
        steps.push_back('{OP_INIT, 32'h0, 8'h00, 8'h00, 1, typed_res(8'hFF, 0, 0, 0, 0, ST_OK)});
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (steps[i]) begin
            s = steps[i];
            send_item(s.op, s.addr, s.rx, s.wb, s.typed, s.want);
        end
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: set_limits(1, 1, 1, 1);
                    2: set_limits(65535, 2097151, 131071, 15);
                    3: set_limits(0, 0, 0, 0);
                    4: set_limits(2, 2, 4, 2);
                    default: set_limits($urandom_range(1, 8), $urandom_range(2, 40),
                                        $urandom_range(1, 20), $urandom_range(1, 15));
                endcase
            end
            limit = (p + 1) * PHASE_ITEMS;
            while (items < limit) run_operation();
        end
        drain();
        if (errors == 0) $display("sd_spi_host_sequencer_tb: done, clean");
        else $display("sd_spi_host_sequencer_tb: done, errors");
        $finish;
    end

    initial begin
        int w;
        res_t e;
        forever begin
            w = calm ? 0 : $urandom_range(0, 13);
            if (w > 0) begin
                res_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid === 1'b1 && rst_n));
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", res);
            end else begin
                e = pending_replies.pop_front();
                if (res.tx_byte !== e.tx_byte || res.chip_select !== e.chip_select ||
                    res.fast_clock !== e.fast_clock || res.data_out !== e.data_out ||
                    res.data_out_valid !== e.data_out_valid ||
                    res.need_write_byte !== e.need_write_byte ||
                    res.done_res !== e.done_res || res.status !== e.status ||
                    res.card_is_sdhc !== e.card_is_sdhc || res.card_blocks !== e.card_blocks)
                begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", e, res);
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("sd_spi_host_sequencer_tb: done, errors");
        $finish;
    end

endmodule
